// ===== hw/rtl/pcu_pkg.sv =====
// Shared types, codes and constants for the permutation and combination unit.
// Holds the command and status codes, the controller/datapath command structs
// and the factorial look-up table. No dependencies.
package pcu_pkg;

  localparam int MAX_N = 20;

  localparam int COUNT_W = 63;
  localparam int FIELD_W = 6;
  localparam int PROD_W  = COUNT_W + FIELD_W;

  // Command codes
  localparam logic [1:0] CMD_PERM     = 2'd0;
  localparam logic [1:0] CMD_POW      = 2'd1;
  localparam logic [1:0] CMD_COMB     = 2'd2;
  localparam logic [1:0] CMD_MULTISET = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_R_OVER_N = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_ZERO_N   = 2'd3;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture a new transaction
    logic mul_en;     // one multiply step
    logic div_start;  // set up the divider
    logic div_en;     // one restoring divide step
    logic out_load;   // move the result into the output register
  } pcu_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic mul_done;   // no steps left, or an error is already flagged
    logic need_div;   // combination mode with no error
    logic div_done;   // last divide step in progress
  } pcu_sts_t;

  // k! for k up to 20; entries above 20 are never used
  function automatic logic [COUNT_W-1:0] fact_lut(input logic [4:0] k);
    logic [COUNT_W-1:0] f;
    case (k)
      5'd0:    f = 63'd1;
      5'd1:    f = 63'd1;
      5'd2:    f = 63'd2;
      5'd3:    f = 63'd6;
      5'd4:    f = 63'd24;
      5'd5:    f = 63'd120;
      5'd6:    f = 63'd720;
      5'd7:    f = 63'd5040;
      5'd8:    f = 63'd40320;
      5'd9:    f = 63'd362880;
      5'd10:   f = 63'd3628800;
      5'd11:   f = 63'd39916800;
      5'd12:   f = 63'd479001600;
      5'd13:   f = 63'd6227020800;
      5'd14:   f = 63'd87178291200;
      5'd15:   f = 63'd1307674368000;
      5'd16:   f = 63'd20922789888000;
      5'd17:   f = 63'd355687428096000;
      5'd18:   f = 63'd6402373705728000;
      5'd19:   f = 63'd121645100408832000;
      5'd20:   f = 63'd2432902008176640000;
      default: f = 63'd1;
    endcase
    return f;
  endfunction

endpackage

// ===== hw/rtl/pcu_ctrl.sv =====
// Controller state machine for the permutation and combination unit.
// Sequences capture, multiply, divide and output load. Depends on pcu_pkg.
module pcu_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  pcu_pkg::pcu_sts_t sts,
  output pcu_pkg::pcu_cmd_t cmd
);
  import pcu_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        if (sts.mul_done) begin
          if (sts.need_div) begin
            cmd.div_start = 1'b1;
            state_next    = S_DIV;
          end else begin
            state_next = S_FIN;
          end
        end else begin
          cmd.mul_en = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_en = 1'b1;
        if (sts.div_done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== hw/rtl/pcu_dp.sv =====
// Datapath for the permutation and combination unit: range checks, a shared
// 63x6 multiplier, a restoring divider and the output register. Depends on pcu_pkg.
module pcu_dp (
  input  logic                           clk,
  input  logic [1:0]                     command,
  input  logic [pcu_pkg::FIELD_W-1:0]    n,
  input  logic [pcu_pkg::FIELD_W-1:0]    r,
  input  pcu_pkg::pcu_cmd_t              cmd,
  output pcu_pkg::pcu_sts_t              sts,
  output logic [pcu_pkg::COUNT_W-1:0]    count,
  output logic [1:0]                     status
);
  import pcu_pkg::*;

  localparam logic [FIELD_W:0] MaxN1 = (FIELD_W+1)'(MAX_N + 1);
  localparam logic [FIELD_W:0] MaxN  = (FIELD_W+1)'(MAX_N);

  logic [FIELD_W-1:0] factor;
  logic [FIELD_W-1:0] steps;
  logic               incr;
  logic               div_need;
  logic [1:0]         st;
  logic [COUNT_W-1:0] acc;
  logic [COUNT_W-1:0] rem;
  logic [COUNT_W-1:0] divisor;
  logic [FIELD_W-1:0] div_cnt;

  logic [FIELD_W:0]   sum_nr;
  logic [1:0]         ld_st;
  logic [FIELD_W-1:0] ld_factor;
  logic               ld_incr;
  logic               ld_div;
  logic [PROD_W-1:0]  prod;
  logic               prod_over;
  logic [COUNT_W:0]   trial;
  logic [COUNT_W:0]   diff;
  logic               ge;

  assign sum_nr = {1'b0, n} + {1'b0, r};

  // Early checks and loop set-up for a new transaction
  always_comb begin
    ld_st     = ST_OK;
    ld_factor = n;
    ld_incr   = 1'b1;
    ld_div    = 1'b0;
    case (command)
      CMD_PERM, CMD_COMB: begin
        if (r > n) begin
          ld_st = ST_R_OVER_N;
        end else if ({1'b0, n} > MaxN) begin
          ld_st = ST_RANGE;
        end
        ld_factor = n - r + FIELD_W'(1);
        ld_div    = (command == CMD_COMB);
      end
      CMD_POW: begin
        ld_incr = 1'b0;
      end
      CMD_MULTISET: begin
        if (n == '0) begin
          ld_st = ST_ZERO_N;
        end else if (sum_nr > MaxN1) begin
          ld_st = ST_RANGE;
        end
        ld_div = 1'b1;
      end
      default: begin
        ld_st = ST_RANGE;
      end
    endcase
  end

  assign prod      = {{FIELD_W{1'b0}}, acc} * {{COUNT_W{1'b0}}, factor};
  assign prod_over = (prod[PROD_W-1:COUNT_W] != '0);

  assign trial = {rem, acc[COUNT_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = !diff[COUNT_W];

  assign sts.mul_done = (steps == '0) || (st != ST_OK);
  assign sts.need_div = div_need && (st == ST_OK);
  assign sts.div_done = (div_cnt == FIELD_W'(COUNT_W - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      st       <= ld_st;
      factor   <= ld_factor;
      incr     <= ld_incr;
      div_need <= ld_div;
      steps    <= r;
      acc      <= COUNT_W'(1);
      divisor  <= fact_lut(r[4:0]);
    end else if (cmd.mul_en) begin
      if (prod_over) begin
        st <= ST_RANGE;
      end else begin
        acc    <= prod[COUNT_W-1:0];
        steps  <= steps - FIELD_W'(1);
        factor <= factor + FIELD_W'(incr);
      end
    end else if (cmd.div_start) begin
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_en) begin
      rem     <= ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
      acc     <= {acc[COUNT_W-2:0], ge};
      div_cnt <= div_cnt + FIELD_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      count  <= (st == ST_OK) ? acc : '0;
      status <= st;
    end
  end

endmodule

// ===== hw/rtl/permutation_combination_unit.sv =====
// Top level of the permutation and combination unit.
// Joins the controller (pcu_ctrl) and the datapath (pcu_dp). Depends on pcu_pkg.
//
// Usage:
//   Input channel: in_valid / in_stall with command, n and r. A transaction is
//   taken at a rising edge with in_valid high and in_stall low. Commands:
//   ordered selection without repetition, power n^r, unordered selection
//   without repetition and unordered selection with repetition.
//   Output channel: out_valid / out_stall with count and status, one result
//   transaction for every input transaction. count is zero on any flagged status.
//   Sequence: capture, multiply steps on the shared 63x6 multiplier (cut short
//   when a power overflows), a hand-over, then restoring division in the
//   combination modes, and a load of the output register. A transaction with
//   an error flagged at capture skips the multiply and divide steps.
//   One transaction is in work at a time: in_stall is high from capture until
//   the result enters the output register, and no new one is taken meanwhile.
//   A stalled receiver holds the output register; the next transaction may be
//   accepted and computed meanwhile, and waits in its final state until the
//   output register frees.
//   Reset (rst, synchronous) returns the controller to idle and drops out_valid.
module permutation_combination_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  command,
  input  logic [pcu_pkg::FIELD_W-1:0] n,
  input  logic [pcu_pkg::FIELD_W-1:0] r,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pcu_pkg::COUNT_W-1:0] count,
  output logic [1:0]                  status
);
  import pcu_pkg::*;

  pcu_cmd_t cmd;
  pcu_sts_t sts;

  // Sequencing: capture, multiply, divide, load output
  pcu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Arithmetic and the output register
  pcu_dp u_dp (
    .clk     (clk),
    .command (command),
    .n       (n),
    .r       (r),
    .cmd     (cmd),
    .sts     (sts),
    .count   (count),
    .status  (status)
  );

endmodule
